/* hdl/tkrt_pkg.sv */
// Shared types and constants for the top-K rank table update block.
// Used by top_k_rank_table_update; depends on nothing else.
package tkrt_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int GROUPS    = 4;

    localparam int SLOT_W  = 4;
    localparam int GRP_W   = 2;
    localparam int LEN_W   = 5;
    localparam int KEY_W   = 63;
    localparam int SCORE_W = 31;
    localparam int STAMP_W = 32;
    localparam int ADDR_W  = GRP_W + SLOT_W;
    localparam int DEPTH   = GROUPS * MAX_SLOTS;

    localparam int ENTRY_W   = KEY_W + SCORE_W + STAMP_W;
    localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_FIELD_W = SLOT_W + ENTRY_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_SLOTS);
    localparam logic [GRP_W:0]   GRP_LIMIT = (GRP_W + 1)'(GROUPS);

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   key;
    } t_entry;

endpackage

/* hdl/top_k_rank_table_update.sv */
// Top level of the top-K rank table update block: control, table memory and output register.
// Depends on tkrt_pkg.
//
// Usage: an update beat on the slave stream carries key, score and stamp in tdata
// (key lowest) and the group number in tuser. The block keeps one descending table
// per group in a single-port-read memory with a registered read. For each accepted beat
// it scans the used slots of that group, one read per cycle, to find the insert
// position and the key's old slot, then moves entries down one at a time and writes
// the new entry. Every changed slot leaves on the master stream as one beat, the
// inserted entry last with tlast high; an update that changes nothing emits nothing.
// With n the used length capped at 16, an inserting update reads the n used slots in the
// scan, then takes a read step and a write step per shifted slot, then the insert write,
// and then returns to idle; an update that changes nothing returns to idle after the scan.
// The memory's single read port sets this pace. A new update is taken only once the previous
// one has written its last entry, while the final result beat may still wait in the output
// register. When the receiver stalls, the shift and insert steps pause until the output
// register is free. Reset clears the per-entry valid bits, so every table reads as
// zeros at once, and sets list_length to 16. The configuration channel is always ready.
module top_k_rank_table_update (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tkrt_pkg::LEN_W-1:0]        i_cfg_wdata,  // list_length
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [tkrt_pkg::S_TDATA_W-1:0]    i_s_tdata,    // entry_key, entry_score, entry_stamp
    input  logic [tkrt_pkg::GRP_W-1:0]        i_s_tuser,    // group
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [tkrt_pkg::M_TDATA_W-1:0]    o_m_tdata,    // slot, slot_key, slot_score, slot_stamp
    output logic                              o_m_tlast     // last_change
);
    import tkrt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS
    } t_state;

    t_entry              mem [DEPTH];
    logic [DEPTH-1:0]    r_vld;
    t_entry              r_rd_data;
    logic                r_rd_vld;

    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_n, n_n;
    logic [GRP_W-1:0]    r_grp;
    t_entry              r_new;
    logic [LEN_W-1:0]    r_cnt, n_cnt;
    logic                r_scan_vld, n_scan_vld;
    logic [SLOT_W-1:0]   r_scan_slot, n_scan_slot;
    logic                r_ins_found, n_ins_found;
    logic [SLOT_W-1:0]   r_ins, n_ins;
    logic                r_old_found, n_old_found;
    logic [SLOT_W-1:0]   r_old, n_old;
    logic [SLOT_W-1:0]   r_idx, n_idx;

    logic                r_m_tvalid, n_m_tvalid;
    logic                r_m_tlast, n_m_tlast;
    logic [SLOT_W-1:0]   r_m_slot, n_m_slot;
    t_entry              r_m_entry, n_m_entry;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    t_entry              wr_data;
    t_entry              rd_entry;
    logic                out_free;
    logic                s_accept;
    logic [LEN_W-1:0]    len_eff;
    logic [SLOT_W-1:0]   old_sel;
    logic [SLOT_W-1:0]   ins_sel;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tlast   = r_m_tlast;
    assign o_m_tdata   = M_TDATA_W'({r_m_entry, r_m_slot});
    assign out_free    = !r_m_tvalid || i_m_tready;
    assign rd_entry    = r_rd_vld ? r_rd_data : '0;
    assign len_eff     = (r_len > LEN_MAX) ? LEN_MAX : r_len;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_scan_vld  = 1'b0;
        n_scan_slot = r_scan_slot;
        n_ins_found = r_ins_found;
        n_ins       = r_ins;
        n_old_found = r_old_found;
        n_old       = r_old;
        n_idx       = r_idx;
        n_m_tvalid  = r_m_tvalid && !i_m_tready;
        n_m_tlast   = r_m_tlast;
        n_m_slot    = r_m_slot;
        n_m_entry   = r_m_entry;
        rd_en       = 1'b0;
        rd_addr     = {r_grp, r_cnt[SLOT_W-1:0]};
        wr_en       = 1'b0;
        wr_addr     = {r_grp, r_idx};
        wr_data     = rd_entry;
        old_sel     = r_old;
        ins_sel     = r_ins;

        case (r_state)
            ST_IDLE: begin
                n_n         = len_eff;
                n_cnt       = '0;
                n_ins_found = 1'b0;
                n_old_found = 1'b0;
                if (s_accept && ({1'b0, i_s_tuser} < GRP_LIMIT) && (len_eff != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt < r_n) begin
                    rd_en       = 1'b1;
                    n_cnt       = r_cnt + LEN_W'(1);
                    n_scan_vld  = 1'b1;
                    n_scan_slot = r_cnt[SLOT_W-1:0];
                end
                if (r_scan_vld) begin
                    if (!r_ins_found && (rd_entry.score < r_new.score)) begin
                        n_ins_found = 1'b1;
                        n_ins       = r_scan_slot;
                    end
                    if (!r_old_found && (rd_entry.key == r_new.key)) begin
                        n_old_found = 1'b1;
                        n_old       = r_scan_slot;
                    end
                    if ({1'b0, r_scan_slot} == (r_n - LEN_W'(1))) begin
                        old_sel = n_old_found ? n_old : SLOT_W'(r_n - LEN_W'(1));
                        ins_sel = (old_sel < n_ins) ? old_sel : n_ins;
                        n_ins   = ins_sel;
                        n_idx   = old_sel;
                        if (!n_ins_found) begin
                            n_state = ST_IDLE;
                        end else if (old_sel == ins_sel) begin
                            n_state = ST_INS;
                        end else begin
                            n_state = ST_SH_RD;
                        end
                    end
                end
            end
            ST_SH_RD: begin
                rd_en   = 1'b1;
                rd_addr = {r_grp, r_idx - SLOT_W'(1)};
                n_state = ST_SH_WR;
            end
            ST_SH_WR: begin
                if (out_free) begin
                    wr_en      = 1'b1;
                    n_m_tvalid = 1'b1;
                    n_m_tlast  = 1'b0;
                    n_m_slot   = r_idx;
                    n_m_entry  = rd_entry;
                    n_idx      = r_idx - SLOT_W'(1);
                    n_state    = (n_idx == r_ins) ? ST_INS : ST_SH_RD;
                end
            end
            ST_INS: begin
                wr_addr = {r_grp, r_ins};
                wr_data = r_new;
                if (out_free) begin
                    wr_en      = 1'b1;
                    n_m_tvalid = 1'b1;
                    n_m_tlast  = 1'b1;
                    n_m_slot   = r_ins;
                    n_m_entry  = r_new;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_len      <= LEN_RESET;
            r_vld      <= '0;
            r_scan_vld <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_vld <= n_scan_vld;
            r_m_tvalid <= n_m_tvalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_len <= i_cfg_wdata;
            end
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_vld <= r_vld[rd_addr];
        end
        if (s_accept) begin
            r_grp <= i_s_tuser;
            r_new <= i_s_tdata[ENTRY_W-1:0];
        end
        r_n         <= n_n;
        r_cnt       <= n_cnt;
        r_scan_slot <= n_scan_slot;
        r_ins_found <= n_ins_found;
        r_ins       <= n_ins;
        r_old_found <= n_old_found;
        r_old       <= n_old;
        r_idx       <= n_idx;
        r_m_tlast   <= n_m_tlast;
        r_m_slot    <= n_m_slot;
        r_m_entry   <= n_m_entry;
    end

endmodule

/* dv/top_k_rank_table_update_test.sv */
// Self-checking testbench for top_k_rank_table_update: drives update beats, list lengths and
// random stalls, predicts every changed table slot and compares each result beat in order.
// Depends on tkrt_pkg and top_k_rank_table_update.
module top_k_rank_table_update_test;

    import tkrt_pkg::*;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        t_entry            ent;
        logic              last;
    } t_slot_change;

    class rank_table_predictor;
        t_entry             tables [GROUPS][MAX_SLOTS];
        logic [LEN_W-1:0]   used_len;
        t_slot_change       changes_due [$];
        int                 errors;

        function new();
            int g;
            int s;
            for (g = 0; g < GROUPS; g++) begin
                for (s = 0; s < MAX_SLOTS; s++) begin
                    tables[g][s] = '0;
                end
            end
            used_len = LEN_RESET;
            errors   = 0;
        endfunction

        function void set_length(input logic [LEN_W-1:0] len);
            used_len = len;
        endfunction

        function int pending();
            return changes_due.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 100) begin
                $display("mismatch at %0t: %s", $time, msg);
            end
        endtask

        function void apply_update(input logic [GRP_W-1:0] grp, input t_entry ent);
            int g;
            int n;
            int i;
            int ins;
            int old;
            t_slot_change c;
            g = int'(grp);
            if (g >= GROUPS) begin
                return;
            end
            n = (int'(used_len) > MAX_SLOTS) ? MAX_SLOTS : int'(used_len);
            if (n == 0) begin
                return;
            end
            ins = n;
            for (i = n - 1; i >= 0; i--) begin
                if (tables[g][i].score < ent.score) begin
                    ins = i;
                end
            end
            if (ins >= n) begin
                return;
            end
            old = n - 1;
            for (i = n - 1; i >= 0; i--) begin
                if (tables[g][i].key == ent.key) begin
                    old = i;
                end
            end
            if (old < ins) begin
                ins = old;
            end
            for (i = old; i > ins; i--) begin
                tables[g][i] = tables[g][i - 1];
                c.slot = SLOT_W'(i);
                c.ent  = tables[g][i];
                c.last = 1'b0;
                changes_due.insert(changes_due.size(), c);
            end
            tables[g][ins] = ent;
            c.slot = SLOT_W'(ins);
            c.ent  = ent;
            c.last = 1'b1;
            changes_due.insert(changes_due.size(), c);
        endfunction

        task check_change(input logic [SLOT_W-1:0] slot, input t_entry ent, input logic last);
            t_slot_change exp;
            if (changes_due.size() == 0) begin
                report($sformatf("result beat for slot %0d with no change pending", slot));
                return;
            end
            exp = changes_due.pop_front();
            if (slot !== exp.slot) begin
                report($sformatf("slot: got %0d, expected %0d", slot, exp.slot));
            end
            if (ent.key !== exp.ent.key) begin
                report($sformatf("key at slot %0d: got %h, expected %h",
                                 exp.slot, ent.key, exp.ent.key));
            end
            if (ent.score !== exp.ent.score) begin
                report($sformatf("score at slot %0d: got %0d, expected %0d",
                                 exp.slot, ent.score, exp.ent.score));
            end
            if (ent.stamp !== exp.ent.stamp) begin
                report($sformatf("stamp at slot %0d: got %h, expected %h",
                                 exp.slot, ent.stamp, exp.ent.stamp));
            end
            if (last !== exp.last) begin
                report($sformatf("last flag at slot %0d: got %b, expected %b",
                                 exp.slot, last, exp.last));
            end
        endtask
    endclass

    localparam logic [SCORE_W-1:0] SCORE_TOP = {SCORE_W{1'b1}};
    localparam logic [KEY_W-1:0]   KEY_TOP   = {KEY_W{1'b1}};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LEN_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [GRP_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    logic                  hold_req  = 1'b0;
    logic                  quiet     = 1'b0;
    logic [KEY_W-1:0]      key_pool [0:11];
    int                    phase_len [0:7] = '{1, 16, 0, 7, 31, 2, 17, 12};
    rank_table_predictor   sb;

    top_k_rank_table_update uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] wide;
        int r;
        wide = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end
        if (r < 80) begin
            return key_pool[$urandom_range(0, 11)];
        end
        return wide[KEY_W-1:0];
    endfunction

    function automatic logic [SCORE_W-1:0] rand_score();
        logic [31:0] wide;
        int r;
        wide = $urandom;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return SCORE_W'($urandom_range(0, 300));
        end
        if (r < 75) begin
            return wide[SCORE_W-1:0];
        end
        if (r < 88) begin
            return '0;
        end
        return SCORE_TOP;
    endfunction

    task automatic send_update(input logic [GRP_W-1:0] grp, input t_entry ent);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(ent);
        s_tuser  <= grp;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        sb.apply_update(grp, ent);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic put(input logic [GRP_W-1:0] grp, input logic [KEY_W-1:0] key,
                       input logic [SCORE_W-1:0] score, input logic [STAMP_W-1:0] stamp);
        t_entry ent;
        ent.key   = key;
        ent.score = score;
        ent.stamp = stamp;
        send_update(grp, ent);
        pause(gap_len());
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (64) @(posedge clk);
    endtask

    task automatic write_length(input int len);
        cfg_valid <= 1'b1;
        cfg_wdata <= LEN_W'(len);
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sb.set_length(LEN_W'(len));
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_change(m_tdata[SLOT_W-1:0], t_entry'(m_tdata[SLOT_W +: ENTRY_W]), m_tlast);
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req <= 1'b0;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = gap_len();
                m_tready <= (stall_left == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int p;
        int k;
        int count;
        logic [63:0] wide;
        sb = new();
        key_pool[0] = KEY_TOP;
        key_pool[1] = 63'h1;
        for (k = 2; k < 12; k++) begin
            wide = {$urandom, $urandom};
            key_pool[k] = wide[KEY_W-1:0];
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put(2'd0, 63'h1234_5678_9ABC_DEF0, SCORE_TOP, 32'hFFFF_FFFF);
        put(2'd0, '0, 31'd5, 32'h0);
        put(2'd0, KEY_TOP, 31'd1, 32'h8000_0001);
        put(2'd0, 63'h77, '0, 32'h7);
        put(2'd0, 63'h1234_5678_9ABC_DEF0, 31'd10, 32'h1);
        put(2'd0, KEY_TOP, 31'd10, 32'h2);
        put(2'd0, 63'h1234_5678_9ABC_DEF0, SCORE_TOP, 32'h3);
        put(2'd1, 63'h77, 31'd1, 32'h4);
        put(2'd1, 63'h99, 31'd2, 32'h5);
        put(2'd1, 63'h77, 31'd3, 32'h6);
        put(2'd1, 63'h2AAA_AAAA_AAAA_AAAA, 31'h2AAA_AAAA, 32'h5555_5555);
        put(2'd1, 63'h5555_5555_5555_5555, 31'h5555_5555, 32'hAAAA_AAAA);
        put(2'd2, KEY_TOP, SCORE_TOP, 32'h0);
        put(2'd2, 63'h5, '0, 32'h9);
        put(2'd3, 63'h99, 31'd100, 32'hA);
        put(2'd3, '0, 31'd50, 32'hB);
        put(2'd3, 63'h1, 31'd1000, 32'hC);

        for (p = 0; p < 8; p++) begin
            settle();
            write_length(phase_len[p]);
            quiet = (p == 6);
            if (p == 1) begin
                hold_req <= 1'b1;
            end
            count = (phase_len[p] == 0) ? 6 : 30;
            repeat (count) begin
                put(GRP_W'($urandom_range(0, GROUPS - 1)), rand_key(), rand_score(), $urandom);
            end
        end
        settle();

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/tkrt_pkg.sv
hdl/top_k_rank_table_update.sv
dv/top_k_rank_table_update_test.sv
